@@ design/fsc_pkg.sv @@
// shared types, constants and lookup functions of the fuzzy speed controller
package fsc_pkg;

  localparam int unsigned FullScale = 100;

  // register map (word index)
  localparam logic [2:0] RegCxLo  = 3'd0;
  localparam logic [2:0] RegCxHi  = 3'd1;
  localparam logic [2:0] RegLaLo  = 3'd2;
  localparam logic [2:0] RegLaHi  = 3'd3;
  localparam logic [2:0] RegSpSel = 3'd4;

  // divider sizes
  localparam int unsigned ScNumW = 19;
  localparam int unsigned ScDenW = 12;
  localparam int unsigned ScQuoW = 7;
  localparam int unsigned AvNumW = 18;
  localparam int unsigned AvDenW = 9;
  localparam int unsigned AvQuoW = 9;

  localparam logic [6:0] CxBp [7] = '{7'd0, 7'd16, 7'd32, 7'd48, 7'd64, 7'd80, 7'd96};
  localparam logic [6:0] LaBp [7] = '{7'd0, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90};

  localparam logic [8:0] SpeedTab [7][7] = '{
    '{9'd180, 9'd170, 9'd160, 9'd150, 9'd140, 9'd130, 9'd120},
    '{9'd270, 9'd260, 9'd250, 9'd240, 9'd230, 9'd220, 9'd200},
    '{9'd270, 9'd260, 9'd240, 9'd220, 9'd200, 9'd180, 9'd160},
    '{9'd290, 9'd285, 9'd270, 9'd250, 9'd230, 9'd210, 9'd180},
    '{9'd300, 9'd280, 9'd260, 9'd240, 9'd215, 9'd200, 9'd165},
    '{9'd300, 9'd305, 9'd300, 9'd295, 9'd290, 9'd275, 9'd260},
    '{9'd350, 9'd340, 9'd315, 9'd300, 9'd285, 9'd270, 9'd230}
  };

  // rows: complexity segment, columns: lookahead segment
  localparam logic [2:0] LabelTab [7][7] = '{
    '{3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0},
    '{3'd5, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0},
    '{3'd4, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd0},
    '{3'd3, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1, 3'd0},
    '{3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd0, 3'd0},
    '{3'd2, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
  };

  typedef struct packed {
    logic [2:0] seg;
    logic [6:0] comp;
  } loc_t;

  // segment and complement degree on the complexity breakpoints
  function automatic loc_t cx_locate(input logic [6:0] x);
    loc_t        r;
    logic [2:0]  k;
    logic [10:0] p;
    k = 3'd6;
    for (int i = 5; i >= 1; i--) begin
      if (x <= CxBp[i]) k = 3'(i);
    end
    p = 11'(CxBp[k] - x) * 11'(FullScale);
    r.seg  = k;
    r.comp = 7'(p >> 4);
    if (x == 7'd0) begin
      r.seg  = 3'd1;
      r.comp = 7'(FullScale);
    end else if (x >= CxBp[6]) begin
      r.seg  = 3'd6;
      r.comp = 7'd0;
    end
    return r;
  endfunction

  // segment and complement degree on the lookahead breakpoints
  function automatic loc_t la_locate(input logic [6:0] x);
    loc_t        r;
    logic [2:0]  k;
    logic [6:0]  d;
    k = 3'd6;
    for (int i = 5; i >= 1; i--) begin
      if (x <= LaBp[i]) k = 3'(i);
    end
    d = LaBp[k] - x;
    r.seg  = k;
    // first segment is 40 wide (100/40 = 5/2), the others 10 wide (100/10 = 10)
    r.comp = (k == 3'd1) ? 7'((10'(d) * 10'd5) >> 1) : 7'(10'(d) * 10'd10);
    if (x == 7'd0) begin
      r.seg  = 3'd1;
      r.comp = 7'(FullScale);
    end else if (x >= LaBp[6]) begin
      r.seg  = 3'd6;
      r.comp = 7'd0;
    end
    return r;
  endfunction

endpackage

@@ design/fsc_in_if.sv @@
// input channel: complexity and lookahead item
interface fsc_in_if import fsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [15:0] complexity;
  logic signed [15:0] lookahead;

  modport source (output valid, output complexity, output lookahead, input ready);
  modport sink (input valid, input complexity, input lookahead, output ready);
endinterface

@@ design/fsc_out_if.sv @@
// result channel: target speed item
interface fsc_out_if import fsc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [8:0] speed;

  modport source (output valid, output speed, input ready);
  modport sink (input valid, input speed, output ready);
endinterface

@@ design/fsc_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with a side tag
module fsc_div import fsc_pkg::*; #(
  parameter int unsigned NW = ScNumW,
  parameter int unsigned DW = ScDenW,
  parameter int unsigned QW = ScQuoW,
  parameter int unsigned TW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic [QW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);
  localparam int unsigned RW = (NW > DW + QW) ? NW : DW + QW;

  logic [RW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [TW-1:0] tag_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [RW-1:0] rem_in, sh, rem_nxt;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in, quo_nxt;
    logic [TW-1:0] tag_in;
    logic          ge;

    // pick up previous stage or the ports
    if (s == 0) begin : g_first
      assign rem_in = RW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
      assign tag_in = tag_r[s-1];
    end

    // trial subtract of the shifted divisor
    always_comb begin
      sh      = RW'(den_in) << (QW - 1 - s);
      ge      = rem_in >= sh;
      rem_nxt = ge ? rem_in - sh : rem_in;
      quo_nxt = quo_in;
      quo_nxt[QW-1-s] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        den_r[s] <= den_in;
        quo_r[s] <= quo_nxt;
        tag_r[s] <= tag_in;
      end
    end
  end

  assign quo_o = quo_r[QW-1];
  assign tag_o = tag_r[QW-1];
endmodule

@@ design/fuzzy_speed_controller_top.sv @@
// top level of the fuzzy speed controller
//
// Usage: items enter on in_if (complexity, lookahead, signed 16 bit) with a
// valid/ready handshake and leave on out_if as one speed value each, in order.
// Clamp ranges and the speed table are set through the cfg_ APB port, one
// register per word; write them only while no item is in flight.
// Pipeline: 22 register stages. Throughput: one item per cycle unless a
// waiting result stalls the pipeline. Most stages lie in the two pipelined
// dividers, one quotient bit per stage: a 7-stage divider for input scaling
// and a 9-stage divider for the weighted average, plus six stages of clamp,
// fuzzify, rule, multiply, sum and output register.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// ranges (30..75, 30..450) and speed table 0.
// When the receiver holds out_if.ready low with a result waiting, the whole
// pipeline freezes and in_if.ready drops; nothing is lost or repeated, and
// empty stages are not filled until out_if.ready returns.
module fuzzy_speed_controller_top import fsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fsc_in_if.sink      in_if,
  fsc_out_if.source   out_if,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int unsigned Lat = 4 + ScQuoW + AvQuoW + 2;

  logic [9:0]  cx_lo_r, cx_hi_r;
  logic [11:0] la_lo_r, la_hi_r;
  logic [2:0]  sp_sel_r;
  logic [2:0]  reg_idx;
  logic        en;
  logic        vld_r [Lat];

  // configuration registers
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_lo_r  <= 10'd30;
      cx_hi_r  <= 10'd75;
      la_lo_r  <= 12'd30;
      la_hi_r  <= 12'd450;
      sp_sel_r <= 3'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (reg_idx)
        RegCxLo:  cx_lo_r  <= cfg_pwdata[9:0];
        RegCxHi:  cx_hi_r  <= cfg_pwdata[9:0];
        RegLaLo:  la_lo_r  <= cfg_pwdata[11:0];
        RegLaHi:  la_hi_r  <= cfg_pwdata[11:0];
        RegSpSel: sp_sel_r <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegCxLo:  cfg_prdata = 32'(cx_lo_r);
      RegCxHi:  cfg_prdata = 32'(cx_hi_r);
      RegLaLo:  cfg_prdata = 32'(la_lo_r);
      RegLaHi:  cfg_prdata = 32'(la_hi_r);
      RegSpSel: cfg_prdata = 32'(sp_sel_r);
      default:  cfg_prdata = 32'd0;
    endcase
  end

  // global advance: the pipeline moves unless a result waits with out_if.ready low
  assign en          = !vld_r[Lat-1] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Lat; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_if.valid;
      for (int i = 1; i < Lat; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // stage a: clamp and scale numerators
  logic signed [16:0] cx_x, cx_l, cx_h, cx_c, la_x, la_l, la_h, la_c;
  logic        cx_empty, la_empty;
  logic [11:0] cx_diff, la_diff;
  logic [ScNumW-1:0] a_cx_num_r, a_la_num_r;
  logic [ScDenW-1:0] a_cx_den_r, a_la_den_r;
  logic [1:0]        a_empty_r;

  always_comb begin
    cx_x = {in_if.complexity[15], in_if.complexity};
    la_x = {in_if.lookahead[15], in_if.lookahead};
    cx_l = $signed({7'd0, cx_lo_r});
    cx_h = $signed({7'd0, cx_hi_r});
    la_l = $signed({5'd0, la_lo_r});
    la_h = $signed({5'd0, la_hi_r});
    cx_c = (cx_x < cx_l) ? cx_l : ((cx_x > cx_h) ? cx_h : cx_x);
    la_c = (la_x < la_l) ? la_l : ((la_x > la_h) ? la_h : la_x);
    cx_diff  = 12'(cx_c - cx_l);
    la_diff  = 12'(la_c - la_l);
    cx_empty = cx_hi_r <= cx_lo_r;
    la_empty = la_hi_r <= la_lo_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_cx_num_r <= ScNumW'(cx_diff) * ScNumW'(FullScale);
      a_la_num_r <= ScNumW'(la_diff) * ScNumW'(FullScale);
      a_cx_den_r <= ScDenW'(cx_hi_r - cx_lo_r);
      a_la_den_r <= la_hi_r - la_lo_r;
      a_empty_r  <= {la_empty, cx_empty};
    end
  end

  // scaling dividers
  logic [ScQuoW-1:0] cx_q, la_q;
  logic [1:0]        cx_tag, la_tag;

  fsc_div #(.NW(ScNumW), .DW(ScDenW), .QW(ScQuoW), .TW(2)) u_cx_div (
    .clk(clk), .en(en), .num_i(a_cx_num_r), .den_i(a_cx_den_r),
    .tag_i(a_empty_r), .quo_o(cx_q), .tag_o(cx_tag)
  );

  fsc_div #(.NW(ScNumW), .DW(ScDenW), .QW(ScQuoW), .TW(2)) u_la_div (
    .clk(clk), .en(en), .num_i(a_la_num_r), .den_i(a_la_den_r),
    .tag_i(a_empty_r), .quo_o(la_q), .tag_o(la_tag)
  );

  // stage b: fuzzify, fetch labels, min weights
  logic [6:0] cs, ls, cd, ld;
  loc_t       cloc, lloc;
  logic [2:0] b_lab_r [4];
  logic [6:0] b_w_r [4];

  always_comb begin
    cs   = cx_tag[0] ? 7'd0 : cx_q;
    ls   = la_tag[1] ? 7'd0 : la_q;
    cloc = cx_locate(cs);
    lloc = la_locate(ls);
    cd   = 7'(FullScale) - cloc.comp;
    ld   = 7'(FullScale) - lloc.comp;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_lab_r[0] <= LabelTab[cloc.seg - 3'd1][lloc.seg - 3'd1];
      b_lab_r[1] <= LabelTab[cloc.seg][lloc.seg - 3'd1];
      b_lab_r[2] <= LabelTab[cloc.seg - 3'd1][lloc.seg];
      b_lab_r[3] <= LabelTab[cloc.seg][lloc.seg];
      b_w_r[0]   <= (cloc.comp < lloc.comp) ? cloc.comp : lloc.comp;
      b_w_r[1]   <= (cd < lloc.comp) ? cd : lloc.comp;
      b_w_r[2]   <= (cloc.comp < ld) ? cloc.comp : ld;
      b_w_r[3]   <= (cd < ld) ? cd : ld;
    end
  end

  // stage c: drop the weaker of rules sharing a label, look up speeds
  logic [6:0] wz [4];
  logic [2:0] sel;
  logic [6:0] c_w_r [4];
  logic [8:0] c_spd_r [4];

  always_comb begin
    for (int i = 0; i < 4; i++) wz[i] = b_w_r[i];
    for (int i = 0; i < 3; i++) begin
      for (int j = i + 1; j < 4; j++) begin
        if (b_lab_r[i] == b_lab_r[j]) begin
          if (wz[i] > wz[j]) wz[j] = 7'd0;
          else wz[i] = 7'd0;
        end
      end
    end
    sel = (sp_sel_r > 3'd6) ? 3'd6 : sp_sel_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        c_w_r[i]   <= wz[i];
        c_spd_r[i] <= SpeedTab[sel][b_lab_r[i]];
      end
    end
  end

  // stage d: products and weight sum
  logic [15:0]       d_prod_r [4];
  logic [AvDenW-1:0] d_den_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) d_prod_r[i] <= 16'(c_w_r[i]) * 16'(c_spd_r[i]);
      d_den_r <= AvDenW'(c_w_r[0]) + AvDenW'(c_w_r[1]) + AvDenW'(c_w_r[2])
               + AvDenW'(c_w_r[3]);
    end
  end

  // stage e: numerator sum
  logic [AvNumW-1:0] e_num_r;
  logic [AvDenW-1:0] e_den_r;
  logic              e_zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      e_num_r  <= AvNumW'(d_prod_r[0]) + AvNumW'(d_prod_r[1]) + AvNumW'(d_prod_r[2])
                + AvNumW'(d_prod_r[3]);
      e_den_r  <= d_den_r;
      e_zero_r <= d_den_r == '0;
    end
  end

  // weighted average divider
  logic [AvQuoW-1:0] av_q;
  logic              av_zero;

  fsc_div #(.NW(AvNumW), .DW(AvDenW), .QW(AvQuoW), .TW(1)) u_av_div (
    .clk(clk), .en(en), .num_i(e_num_r), .den_i(e_den_r),
    .tag_i(e_zero_r), .quo_o(av_q), .tag_o(av_zero)
  );

  // output register
  logic [8:0] speed_r;

  always_ff @(posedge clk) begin
    if (en) begin
      speed_r <= av_zero ? 9'd0 : 9'(av_q);
    end
  end

  assign out_if.valid = vld_r[Lat-1];
  assign out_if.speed = speed_r;
endmodule
